// ===== rtl/core/dep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dep_pkg
// shared sizes and control records for the disjoint edge pair counter
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int DEG_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CFG_W        = 7;
    localparam int EDGES_W      = 11;
    localparam int PAIRS_W      = 21;

    // position of one word in the upper triangle
    typedef struct packed {
        logic             row_start;
        logic             last;
        logic [VTX_W-1:0] col;
        logic [VTX_W-1:0] row;
    } dep_pos_t;

    // degree store write request
    typedef struct packed {
        logic             en;
        logic [VTX_W-1:0] addr;
        logic [DEG_W-1:0] data;
    } dep_wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/dep_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dep_sequencer
// vertex count register and vertex pair walk over the upper triangle
// ----------------------------------------------------------------------------
module dep_sequencer (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire  [dep_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire                          accept,
    output dep_pkg::dep_pos_t            pos
);
    import dep_pkg::*;

    logic [CFG_W-1:0] vertex_count_reg;
    logic [VTX_W-1:0] row_reg, row_next;
    logic [VTX_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] n_eff;
    logic [VTX_W-1:0] last_col;
    logic [VTX_W-1:0] last_row;

    // saturate the vertex count into the supported range
    always_comb begin
        if (int'(vertex_count_reg) < 2) begin
            n_eff = CNT_W'(2);
        end else if (int'(vertex_count_reg) > MAX_VERTICES) begin
            n_eff = CNT_W'(MAX_VERTICES);
        end else begin
            n_eff = CNT_W'(vertex_count_reg);
        end
    end

    assign last_col = VTX_W'(n_eff - CNT_W'(1));
    assign last_row = VTX_W'(n_eff - CNT_W'(2));

    assign pos.row       = row_reg;
    assign pos.col       = col_reg;
    assign pos.row_start = (col_reg == row_reg + VTX_W'(1));
    assign pos.last      = (row_reg == last_row) && (col_reg == last_col);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept) begin
            if (pos.last) begin
                row_next = '0;
                col_next = VTX_W'(1);
            end else if (col_reg == last_col) begin
                row_next = row_reg + VTX_W'(1);
                col_next = row_reg + VTX_W'(2);
            end else begin
                col_next = col_reg + VTX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= CFG_W'(2);
            row_reg          <= '0;
            col_reg          <= VTX_W'(1);
        end else if (cfg_wr_en) begin
            vertex_count_reg <= cfg_wr_data;
            row_reg          <= '0;
            col_reg          <= VTX_W'(1);
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dep_degree_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dep_degree_store
// per vertex degree memory, valid bits per entry, registered reads with bypass
// ----------------------------------------------------------------------------
module dep_degree_store (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          clear,
    input  wire                          rd_en,
    input  wire  [dep_pkg::VTX_W-1:0]    rd_col_addr,
    input  wire  [dep_pkg::VTX_W-1:0]    rd_row_addr,
    input  dep_pkg::dep_wr_t             wr,
    output logic [dep_pkg::DEG_W-1:0]    col_deg,
    output logic [dep_pkg::DEG_W-1:0]    row_deg
);
    import dep_pkg::*;

    logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] valid_reg;
    logic [DEG_W-1:0]        col_deg_reg;
    logic [DEG_W-1:0]        row_deg_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            deg_mem[wr.addr] <= wr.data;
        end
    end

    // clearing a graph drops every entry back to zero at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (clear) begin
                col_deg_reg <= '0;
            end else if (wr.en && (wr.addr == rd_col_addr)) begin
                col_deg_reg <= wr.data;
            end else if (valid_reg[rd_col_addr]) begin
                col_deg_reg <= deg_mem[rd_col_addr];
            end else begin
                col_deg_reg <= '0;
            end

            if (clear) begin
                row_deg_reg <= '0;
            end else if (wr.en && (wr.addr == rd_row_addr)) begin
                row_deg_reg <= wr.data;
            end else if (valid_reg[rd_row_addr]) begin
                row_deg_reg <= deg_mem[rd_row_addr];
            end else begin
                row_deg_reg <= '0;
            end
        end
    end

    assign col_deg = col_deg_reg;
    assign row_deg = row_deg_reg;

endmodule
`default_nettype wire

// ===== rtl/core/dep_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dep_datapath
// pair accumulation, edge count, row degree and result register
// ----------------------------------------------------------------------------
module dep_datapath (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_clear,
    input  wire                          advance,
    input  wire                          edge_bit,
    input  dep_pkg::dep_pos_t            pos,
    input  wire  [dep_pkg::DEG_W-1:0]    col_deg,
    input  wire  [dep_pkg::DEG_W-1:0]    row_deg_rd,
    output dep_pkg::dep_wr_t             wr,
    output logic                         out_block,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [dep_pkg::PAIRS_W-1:0]  m_disjoint_pairs,
    output logic [dep_pkg::EDGES_W-1:0]  m_edge_total
);
    import dep_pkg::*;

    logic [EDGES_W-1:0] edges_reg, edges_next;
    logic [PAIRS_W-1:0] acc_reg, acc_next;
    logic [DEG_W-1:0]   row_deg_reg, row_deg_cur, row_deg_next;
    logic [EDGES_W-1:0] others;
    logic               m_valid_reg, m_valid_next;
    logic [PAIRS_W-1:0] pairs_out_reg;
    logic [EDGES_W-1:0] edges_out_reg;

    // row degree comes from the store at the first pair of a row
    assign row_deg_cur = pos.row_start ? row_deg_rd : row_deg_reg;
    assign others      = edges_reg - EDGES_W'(row_deg_cur) - EDGES_W'(col_deg);

    always_comb begin
        edges_next   = edges_reg;
        acc_next     = acc_reg;
        row_deg_next = row_deg_cur;
        if (edge_bit) begin
            edges_next   = edges_reg + EDGES_W'(1);
            acc_next     = acc_reg + PAIRS_W'(others);
            row_deg_next = row_deg_cur + DEG_W'(1);
        end
    end

    assign wr.en   = advance && edge_bit && !pos.last;
    assign wr.addr = pos.col;
    assign wr.data = col_deg + DEG_W'(1);

    assign out_block = m_valid_reg && !m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance && pos.last) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            edges_reg   <= '0;
            acc_reg     <= '0;
            row_deg_reg <= '0;
        end else if (advance) begin
            if (pos.last) begin
                edges_reg   <= '0;
                acc_reg     <= '0;
                row_deg_reg <= '0;
            end else begin
                edges_reg   <= edges_next;
                acc_reg     <= acc_next;
                row_deg_reg <= row_deg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && pos.last) begin
            pairs_out_reg <= acc_next;
            edges_out_reg <= edges_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_disjoint_pairs = pairs_out_reg;
    assign m_edge_total     = edges_out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/disjoint_edge_pair_counter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disjoint_edge_pair_counter_unit
// counts edge pairs sharing no vertex over a streamed upper-triangle adjacency
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one adjacency bit per word, in the order (0,1), (0,2), ...,
//   (0,n-1), (1,2), ..., (n-2,n-1); the unit tracks the pair position itself
//   m_ channel: one word per graph after its last pair, carrying the count of
//   disjoint edge pairs and the number of edges in the graph
//   cfg_wr_en / cfg_wr_data: vertex count n, saturated into 2..MAX_VERTICES;
//   a write also restarts the stream at pair (0,1); write only when idle
// timing
//   one input word per cycle, including across graph boundaries, unless a
//   last pair is stalled; an accepted word waits in the input register and is
//   processed there, and m_valid is registered as the last pair is processed
//   the rate is set by the degree memory: one column read and one write per
//   cycle, plus a row read that is only used at the first pair of a row
// reset and stall
//   reset sets n = 2, zeroes the degree store valid bits and all counters
//   a stalled receiver only holds back the last pair of the next graph; all
//   other words keep flowing while a result waits in the output register
// ----------------------------------------------------------------------------
module disjoint_edge_pair_counter_unit (
    input  wire                          aclk,
    input  wire                          aresetn,
    // configuration
    input  wire                          cfg_wr_en,
    input  wire  [dep_pkg::CFG_W-1:0]    cfg_wr_data,
    // input words
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_edge_present,
    // result words
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [dep_pkg::PAIRS_W-1:0]  m_disjoint_pairs,
    output logic [dep_pkg::EDGES_W-1:0]  m_edge_total
);
    import dep_pkg::*;

    // position of the next word to be accepted
    dep_pos_t         seq_pos;
    // input register stage
    logic             in_valid_reg;
    logic             in_edge_reg;
    dep_pos_t         in_pos_reg;
    // degree store side
    dep_wr_t          deg_wr;
    logic [DEG_W-1:0] col_deg;
    logic [DEG_W-1:0] row_deg;
    logic             store_clear;
    // handshake
    logic             accept;
    logic             advance;
    logic             out_block;

    // the input stage only stalls on the last pair of a graph while the
    // previous result has not been taken
    assign advance = in_valid_reg && !(in_pos_reg.last && out_block);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // end of graph or new vertex count wipes the degree store
    assign store_clear = (advance && in_pos_reg.last) || cfg_wr_en;

    dep_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .pos         (seq_pos)
    );

    // reads are issued with the accept so data lines up with the input register
    dep_degree_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (store_clear),
        .rd_en       (accept),
        .rd_col_addr (seq_pos.col),
        .rd_row_addr (seq_pos.row),
        .wr          (deg_wr),
        .col_deg     (col_deg),
        .row_deg     (row_deg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_edge_reg <= s_edge_present;
            in_pos_reg  <= seq_pos;
        end
    end

    dep_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_clear        (cfg_wr_en),
        .advance          (advance),
        .edge_bit         (in_edge_reg),
        .pos              (in_pos_reg),
        .col_deg          (col_deg),
        .row_deg_rd       (row_deg),
        .wr               (deg_wr),
        .out_block        (out_block),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_disjoint_pairs (m_disjoint_pairs),
        .m_edge_total     (m_edge_total)
    );

`ifndef SYNTHESIS
    // the last pair of a graph always lands a result in the output register
    a_last_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && in_pos_reg.last && !cfg_wr_en) |=> m_valid
    ) else $error("last pair did not produce a result");

    // back pressure reaches the input only through a waiting final pair
    a_stall_only_on_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_pos_reg.last && m_valid && !m_ready)
    ) else $error("input stalled without a blocked final pair");

    // a disjoint count can never exceed the number of edge pairs
    a_count_bound: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_disjoint_pairs) * 32'd2
                     <= 32'(m_edge_total) * (32'(m_edge_total) - 32'd1)
                     || m_edge_total == '0)
    ) else $error("disjoint pair count above edge pair count");

    // no degree write is issued for the pair that closes a graph
    a_no_write_on_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && in_pos_reg.last) |-> !deg_wr.en
    ) else $error("degree write on final pair");
`endif

endmodule
`default_nettype wire
